### sv/efpf_pkg.sv
// Shared types and constants for the edge-flag polygon fill block.
// No dependencies; every other file of the block but efpf_ram imports this package.
package efpf_pkg;

  localparam int COORD_W = 6;
  localparam int ROW_W   = 64;

  localparam logic OP_DRAW    = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ROW   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_OUT,
    ST_SETUP,
    ST_PIXEL,
    ST_WRITE,
    ST_EMIT
  } efpf_state_t;

endpackage

### sv/efpf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the fill bitmap, one row per entry.
module efpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/edge_flag_polygon_fill.sv
// Edge-flag polygon fill: a draw word walks a Bresenham line over a square bitmap,
// emits one output word per line pixel and toggles the bits right of the line on
// each new row, but for the start row of a line that runs left and down; a read word
// returns one bitmap row. The block holds one input word at a time. A draw word
// passes a setup state, then for each line pixel a pixel state, a write state on each
// pixel that toggles a row (the read-modify-write of that row in the bitmap RAM) and
// an emit state that waits while the output is stalled. A read word passes a read
// state and an output state. Reset clears the bitmap at once through per-row valid
// flags. Depends on efpf_pkg and efpf_ram.
module edge_flag_polygon_fill import efpf_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               operation,
  input  logic [COORD_W-1:0] x_start,
  input  logic [COORD_W-1:0] y_start,
  input  logic [COORD_W-1:0] x_end,
  input  logic [COORD_W-1:0] y_end,
  input  logic [COORD_W-1:0] row_index,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               kind,
  output logic [COORD_W-1:0] pixel_x,
  output logic [COORD_W-1:0] pixel_y,
  output logic [ROW_W-1:0]   row_bits,
  output logic               last
);

  localparam int AW = $clog2(GRID_SIZE);
  localparam int EW = AW + 3;

  function automatic logic [AW-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] lim;
    lim = COORD_W'(GRID_SIZE - 1);
    return (v > lim) ? AW'(lim) : AW'(v);
  endfunction

  efpf_state_t state, state_next;

  logic [AW-1:0] rd_row;
  logic          rd_ok;
  logic [AW-1:0] x0, y0, x1, y1;
  logic [AW-1:0] x, y, prev_y, cnt;
  logic [AW-1:0] major, minor;
  logic          xmajor, left, down, skip_start, first;
  logic signed [EW-1:0] err;
  logic [GRID_SIZE-1:0] row_vld;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [GRID_SIZE-1:0] ram_wdata, ram_rdata, tog_mask;

  logic          accept, slot_free, load_pixel, load_row, toggle, pix_last;
  logic [AW-1:0] dx, dy;
  logic signed [EW-1:0] e1, err_next, major_s, minor_s;
  logic          minor_step, x_moves, y_moves;
  logic [AW-1:0] x_step, y_step;

  efpf_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;

  assign dx = (x1 < x0) ? (x0 - x1) : (x1 - x0);
  assign dy = (y1 < y0) ? (y0 - y1) : (y1 - y0);

  // Bresenham error update and coordinate step for the pixel just emitted.
  assign major_s    = $signed(EW'(major));
  assign minor_s    = $signed(EW'(minor));
  assign e1         = err + minor_s;
  assign minor_step = (e1 <<< 1) >= major_s;
  assign err_next   = minor_step ? (e1 - major_s) : e1;
  assign x_moves    = (x1 != x0) && (xmajor || minor_step);
  assign y_moves    = (y1 != y0) && (!xmajor || minor_step);
  assign x_step     = x_moves ? (left ? x - 1'b1 : x + 1'b1) : x;
  assign y_step     = y_moves ? (down ? y - 1'b1 : y + 1'b1) : y;

  assign toggle   = (first || (y != prev_y)) && !(skip_start && (y == y0));
  assign tog_mask = ({GRID_SIZE{1'b1}} << x) << 1;
  assign pix_last = (cnt == major);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = y;
    ram_we     = 1'b0;
    ram_waddr  = y;
    ram_wdata  = (row_vld[y] ? ram_rdata : '0) ^ tog_mask;
    load_pixel = 1'b0;
    load_row   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (operation == OP_READ) ? ST_READ : ST_SETUP;
        end
      end
      ST_READ: begin
        ram_re     = rd_ok;
        ram_raddr  = rd_row;
        state_next = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        if (slot_free) begin
          load_row   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: begin
        state_next = ST_PIXEL;
      end
      ST_PIXEL: begin
        ram_re     = toggle;
        state_next = toggle ? ST_WRITE : ST_EMIT;
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_pixel = 1'b1;
          state_next = pix_last ? ST_IDLE : ST_PIXEL;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (ram_we) begin
      row_vld[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= AW'(row_index);
      rd_ok  <= {1'b0, row_index} < (COORD_W + 1)'(GRID_SIZE);
      x0     <= clamp_coord(x_start);
      y0     <= clamp_coord(y_start);
      x1     <= clamp_coord(x_end);
      y1     <= clamp_coord(y_end);
    end
    if (state == ST_SETUP) begin
      left       <= x1 < x0;
      down       <= y1 < y0;
      skip_start <= (x1 < x0) && (y1 < y0);
      xmajor     <= dx >= dy;
      major      <= (dx >= dy) ? dx : dy;
      minor      <= (dx >= dy) ? dy : dx;
      x          <= x0;
      y          <= y0;
      err        <= '0;
      first      <= 1'b1;
      cnt        <= '0;
    end
    if (load_pixel) begin
      prev_y <= y;
      first  <= 1'b0;
      cnt    <= cnt + 1'b1;
      err    <= err_next;
      x      <= x_step;
      y      <= y_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_pixel || load_row) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pixel) begin
      kind     <= KIND_PIXEL;
      pixel_x  <= COORD_W'(x);
      pixel_y  <= COORD_W'(y);
      row_bits <= '0;
      last     <= pix_last;
    end else if (load_row) begin
      kind     <= KIND_ROW;
      pixel_x  <= '0;
      pixel_y  <= '0;
      row_bits <= (rd_ok && row_vld[rd_row]) ? ROW_W'(ram_rdata) : '0;
      last     <= 1'b1;
    end
  end

endmodule

### sv/efpf_check.sv
// Port-level checks for the edge-flag polygon fill block, bound to its top level.
// Depends on efpf_pkg and edge_flag_polygon_fill.
module efpf_check import efpf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic               kind,
  input logic [COORD_W-1:0] pixel_x,
  input logic [COORD_W-1:0] pixel_y,
  input logic [ROW_W-1:0]   row_bits,
  input logic               last
);

  // A stalled output word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(pixel_x)
      && $stable(pixel_y) && $stable(row_bits) && $stable(last))
    else $error("stalled output word changed");

  // A row read always yields exactly one word.
  a_row_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ROW) |-> last)
    else $error("row word without last");

  a_row_coords: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ROW) |-> (pixel_x == '0) && (pixel_y == '0))
    else $error("row word with nonzero coordinates");

  a_pixel_bits: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_PIXEL) |-> (row_bits == '0))
    else $error("pixel word with row bits");

  // While a line is still being walked, no new input word is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> !item_ready)
    else $error("input taken in the middle of a line");

endmodule

bind edge_flag_polygon_fill efpf_check u_efpf_check (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .kind        (kind),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .row_bits    (row_bits),
  .last        (last)
);

### dv/edge_flag_polygon_fill_checker.sv
// Checker for the edge-flag polygon fill block: watches both channels, keeps a shadow
// bitmap, predicts every output word and compares it with what the block returns.
// Depends on efpf_pkg.
module edge_flag_polygon_fill_checker import efpf_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic               operation,
  input  logic [COORD_W-1:0] x_start,
  input  logic [COORD_W-1:0] y_start,
  input  logic [COORD_W-1:0] x_end,
  input  logic [COORD_W-1:0] y_end,
  input  logic [COORD_W-1:0] row_index,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic               kind,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [ROW_W-1:0]   row_bits,
  input  logic               last,
  output int                 mismatch_count,
  output int                 pending_words
);

  localparam logic [ROW_W-1:0] ROW_MASK =
    (GRID_SIZE >= 64) ? {ROW_W{1'b1}} : ((64'd1 << GRID_SIZE) - 64'd1);

  typedef struct {
    logic               kind;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ROW_W-1:0]   bits;
    logic               last;
  } out_word_t;

  out_word_t        due_words[$];
  logic [ROW_W-1:0] shadow_rows [64];
  out_word_t        got_word;
  out_word_t        want_word;
  int               miss_total = 0;

  function automatic int clamp_coord(logic [COORD_W-1:0] v);
    return (int'(v) > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(v);
  endfunction

  task automatic toggle_right(int x, int y);
    if (x < 63) begin
      shadow_rows[y & 63] ^= ({ROW_W{1'b1}} << (x + 1)) & ROW_MASK;
    end
  endtask

  task automatic trace_edge(logic [COORD_W-1:0] xs, logic [COORD_W-1:0] ys,
                            logic [COORD_W-1:0] xe, logic [COORD_W-1:0] ye);
    int        x0, y0, x1, y1, x, y, dx, dy, major, minor, err, n, prev_y;
    bit        xmajor, left, down, skip_start, have_prev;
    out_word_t w;
    x0 = clamp_coord(xs);
    y0 = clamp_coord(ys);
    x1 = clamp_coord(xe);
    y1 = clamp_coord(ye);
    left = x1 < x0;
    down = y1 < y0;
    dx = left ? x0 - x1 : x1 - x0;
    dy = down ? y0 - y1 : y1 - y0;
    xmajor = dx >= dy;
    major = xmajor ? dx : dy;
    minor = xmajor ? dy : dx;
    skip_start = left && down;
    x = x0;
    y = y0;
    err = 0;
    have_prev = 0;
    prev_y = 0;
    n = major + 1;
    for (int k = 0; k < n; k++) begin
      if (!have_prev || prev_y != y) begin
        if (!(skip_start && y == y0)) begin
          toggle_right(x, y);
        end
      end
      have_prev = 1;
      prev_y = y;
      w.kind = KIND_PIXEL;
      w.px = x[COORD_W-1:0];
      w.py = y[COORD_W-1:0];
      w.bits = '0;
      w.last = (k == n - 1);
      due_words.push_back(w);
      err += minor;
      if (2 * err >= major) begin
        err -= major;
        if (xmajor) begin
          if (y1 != y0) y = down ? y - 1 : y + 1;
        end else begin
          if (x1 != x0) x = left ? x - 1 : x + 1;
        end
      end
      if (xmajor) begin
        if (x1 != x0) x = left ? x - 1 : x + 1;
      end else begin
        if (y1 != y0) y = down ? y - 1 : y + 1;
      end
      x &= 63;
      y &= 63;
    end
  endtask

  function automatic int field_miss(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 64; r++) shadow_rows[r] = '0;
      due_words.delete();
    end else begin
      if (item_valid && item_ready) begin
        if (operation == OP_READ) begin
          want_word.kind = KIND_ROW;
          want_word.px = '0;
          want_word.py = '0;
          want_word.bits = (int'(row_index) < GRID_SIZE) ? shadow_rows[row_index] : '0;
          want_word.last = 1'b1;
          due_words.push_back(want_word);
        end else begin
          trace_edge(x_start, y_start, x_end, y_end);
        end
      end
      if (result_valid && result_ready) begin
        if (due_words.size() == 0) begin
          $error("output word with nothing expected: kind %0d x %0d y %0d bits 0x%0h",
                 kind, pixel_x, pixel_y, row_bits);
          miss_total++;
        end else begin
          got_word = due_words.pop_front();
          miss_total += field_miss("kind", 64'(got_word.kind), 64'(kind));
          miss_total += field_miss("pixel_x", 64'(got_word.px), 64'(pixel_x));
          miss_total += field_miss("pixel_y", 64'(got_word.py), 64'(pixel_y));
          miss_total += field_miss("row_bits", got_word.bits, row_bits);
          miss_total += field_miss("last", 64'(got_word.last), 64'(last));
        end
      end
    end
    mismatch_count <= miss_total;
    pending_words <= due_words.size();
  end

endmodule

### dv/edge_flag_polygon_fill_test.sv
// Top of the edge-flag polygon fill testbench: clock, reset, directed and random
// polygon words, output back-pressure and the verdict.
// Depends on efpf_pkg, edge_flag_polygon_fill and edge_flag_polygon_fill_checker.
module edge_flag_polygon_fill_test;
  import efpf_pkg::*;

  localparam int GRID_SIZE    = 64;
  localparam int TARGET_WORDS = 270;
  localparam int LIMIT        = 4_000_000;
  localparam int DRAIN_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic               operation = OP_DRAW;
  logic [COORD_W-1:0] x_start = '0;
  logic [COORD_W-1:0] y_start = '0;
  logic [COORD_W-1:0] x_end = '0;
  logic [COORD_W-1:0] y_end = '0;
  logic [COORD_W-1:0] row_index = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               kind;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [ROW_W-1:0]   row_bits;
  logic               last;
  int                 mismatch_count;
  int                 pending_words;

  int words_sent = 0;
  bit calm = 0;
  bit ready_always = 0;
  int stall_left = 0;
  int cycle_count = 0;

  edge_flag_polygon_fill #(.GRID_SIZE(GRID_SIZE)) u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .operation(operation),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .row_index(row_index),
    .result_valid(result_valid), .result_ready(result_ready), .kind(kind),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .row_bits(row_bits), .last(last)
  );

  edge_flag_polygon_fill_checker #(.GRID_SIZE(GRID_SIZE)) u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .operation(operation),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .row_index(row_index),
    .result_valid(result_valid), .result_ready(result_ready), .kind(kind),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .row_bits(row_bits), .last(last),
    .mismatch_count(mismatch_count), .pending_words(pending_words)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (ready_always) begin
      result_ready <= 1'b1;
    end else begin
      result_ready <= ($urandom_range(0, 3) != 0);
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [COORD_W-1:0] xs, logic [COORD_W-1:0] ys,
                           logic [COORD_W-1:0] xe, logic [COORD_W-1:0] ye,
                           logic [COORD_W-1:0] ri);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    row_index <= ri;
    @(negedge clk);
    while (!item_ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic draw_edge(int xs, int ys, int xe, int ye);
    send_word(OP_DRAW, COORD_W'(xs), COORD_W'(ys), COORD_W'(xe), COORD_W'(ye),
              COORD_W'($urandom));
  endtask

  task automatic read_row(int r);
    send_word(OP_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), COORD_W'(r));
  endtask

  task automatic wait_drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic draw_polygon();
    int vx[6];
    int vy[6];
    int nverts, span, bx, by;
    nverts = $urandom_range(3, 6);
    span = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(1, 20);
    bx = $urandom_range(0, 63 - span);
    by = $urandom_range(0, 63 - span);
    for (int i = 0; i < nverts; i++) begin
      vx[i] = bx + $urandom_range(0, span);
      vy[i] = by + $urandom_range(0, span);
    end
    for (int i = 0; i < nverts; i++) begin
      draw_edge(vx[i], vy[i], vx[(i + 1) % nverts], vy[(i + 1) % nverts]);
    end
    repeat ($urandom_range(2, 4)) read_row(by + $urandom_range(0, span));
  endtask

  initial begin
    int choice;
    bit pressure_done;
    pressure_done = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    calm = 1;
    ready_always = 1;
    read_row(0);
    draw_edge(10, 10, 10, 10);
    read_row(10);
    draw_edge(0, 5, 63, 5);
    draw_edge(63, 6, 0, 6);
    read_row(5);
    draw_edge(20, 0, 20, 63);
    draw_edge(21, 63, 21, 0);
    read_row(33);
    calm = 0;
    ready_always = 0;
    draw_edge(50, 40, 10, 30);
    draw_edge(40, 50, 35, 10);
    read_row(40);
    draw_edge(0, 0, 63, 63);
    draw_edge(63, 0, 0, 63);
    draw_edge(63, 63, 0, 0);
    draw_edge(63, 20, 63, 20);
    read_row(20);
    draw_edge(0, 63, 63, 0);
    read_row(63);
    read_row(0);
    wait_drain();

    while (words_sent < TARGET_WORDS) begin
      choice = $urandom_range(0, 99);
      calm = ($urandom_range(0, 5) == 0);
      ready_always = ($urandom_range(0, 4) == 0);
      if (choice < 65) begin
        draw_polygon();
      end else if (choice < 80) begin
        draw_edge($urandom, $urandom, $urandom, $urandom);
      end else begin
        repeat ($urandom_range(1, 4)) read_row($urandom);
      end
      if (!pressure_done && words_sent > TARGET_WORDS / 2) begin
        wait_drain();
        pressure_done = 1;
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
sv/efpf_pkg.sv
sv/efpf_ram.sv
sv/edge_flag_polygon_fill.sv
sv/efpf_check.sv
dv/edge_flag_polygon_fill_checker.sv
dv/edge_flag_polygon_fill_test.sv
